@@ rtl/bss_pkg.sv @@
// Package for the bounded set store: sizes, request and status codes, cell types.
package bss_pkg;

    localparam int CAPACITY = 16;
    localparam int ELEM_W   = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int SIZE_W   = 5;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd4;

    // Commands broadcast from the controller to every cell.
    typedef struct packed {
        logic              cmp;
        logic              add;
        logic              del;
        logic [ELEM_W-1:0] cmp_elem;
        logic [ELEM_W-1:0] wr_elem;
    } t_cell_cmd;

    // Flags that ripple from one cell to the next along the row.
    typedef struct packed {
        logic hit_seen;
        logic free_seen;
    } t_link;

    // The reported size is the count taken modulo 2**SIZE_W.
    function automatic logic [SIZE_W-1:0] to_size(input logic [CNT_W-1:0] count);
        logic [CNT_W+SIZE_W-1:0] wide;
        wide = (CNT_W + SIZE_W)'(count);
        return wide[SIZE_W-1:0];
    endfunction

endpackage

@@ rtl/bss_if.sv @@
// Channel interfaces for requests and results of the bounded set store.
interface bss_req_if;
    logic                         valid;
    logic                         ready;
    logic [bss_pkg::KIND_W-1:0]   kind;
    logic [bss_pkg::ELEM_W-1:0]   element;

    modport source (output valid, output kind, output element, input ready);
    modport sink   (input valid, input kind, input element, output ready);
endinterface

interface bss_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bss_pkg::STATUS_W-1:0] status;
    logic [bss_pkg::SIZE_W-1:0]   size;

    modport source (output valid, output status, output size, input ready);
    modport sink   (input valid, input status, input size, output ready);
endinterface

@@ rtl/bss_cell.sv @@
// One storage cell of the set: a value, its valid bit and the registered match flag.
module bss_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bss_pkg::t_cell_cmd  i_cmd,
    input  bss_pkg::t_link      i_link,
    output bss_pkg::t_link      o_link,
    output logic                o_valid,
    output logic                o_hit
);

    logic                       r_valid;
    logic                       r_hit;
    logic [bss_pkg::ELEM_W-1:0] r_value;
    logic                       w_claim;

    // This cell is the lowest free one when no cell to its left was free.
    assign w_claim = !r_valid && !i_link.free_seen;

    assign o_link.hit_seen  = i_link.hit_seen || r_hit;
    assign o_link.free_seen = i_link.free_seen || !r_valid;
    assign o_valid          = r_valid;
    assign o_hit            = r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            if (i_cmd.cmp) begin
                r_hit <= r_valid && (r_value == i_cmd.cmp_elem);
            end
            if (i_cmd.add && w_claim) begin
                r_valid <= 1'b1;
            end else if (i_cmd.del && r_hit) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add && w_claim) begin
            r_value <= i_cmd.wr_elem;
        end
    end

endmodule

@@ rtl/bounded_set_store_unit.sv @@
// Top level of the bounded set store: request control, cell row and result register.
//
//   channel | dir | payload          | accepted when
//   i_req   | in  | kind, element    | valid && ready
//   o_rsp   | out | status, size     | valid && ready
//
// The accept edge registers every cell's compare; once the result register is free,
// the update applies the add or remove through the row of cells and loads the
// result register. A new request is taken only after the update, so the store
// does not start a request before it is through with the last one.
// Reset empties the set at once; no clearing pass is needed.
// A result held by a stalled o_rsp blocks the update of the following request, and with it any further request.
module bounded_set_store_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bss_req_if.sink    i_req,
    bss_rsp_if.source  o_rsp
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_UPD  = 1'b1;

    logic                            r_state;
    logic                            n_state;
    logic [bss_pkg::KIND_W-1:0]      r_kind;
    logic [bss_pkg::ELEM_W-1:0]      r_elem;
    logic [bss_pkg::CNT_W-1:0]       r_count;
    logic [bss_pkg::CNT_W-1:0]       n_count;
    logic                            r_out_valid;
    logic [bss_pkg::STATUS_W-1:0]    r_status;
    logic [bss_pkg::STATUS_W-1:0]    n_status;
    logic [bss_pkg::SIZE_W-1:0]      r_size;

    logic                            w_accept;
    logic                            w_upd_fire;
    logic                            w_any_hit;
    logic                            w_any_free;
    bss_pkg::t_cell_cmd              w_cmd;
    bss_pkg::t_link                  w_link [bss_pkg::CAPACITY+1];
    logic [bss_pkg::CAPACITY-1:0]    w_valid;
    logic [bss_pkg::CAPACITY-1:0]    w_hit;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_upd_fire  = (r_state == ST_UPD) && (!r_out_valid || o_rsp.ready);

    assign w_link[0].hit_seen  = 1'b0;
    assign w_link[0].free_seen = 1'b0;
    assign w_any_hit  = w_link[bss_pkg::CAPACITY].hit_seen;
    assign w_any_free = w_link[bss_pkg::CAPACITY].free_seen;

    assign w_cmd.cmp      = w_accept;
    assign w_cmd.cmp_elem = i_req.element;
    assign w_cmd.wr_elem  = r_elem;
    assign w_cmd.add      = w_upd_fire && (r_kind == bss_pkg::KIND_ADD) && !w_any_hit;
    // With an empty set no cell can hit, so a remove needs no count check here.
    assign w_cmd.del      = w_upd_fire && (r_kind == bss_pkg::KIND_REMOVE);

    genvar g;
    generate
        for (g = 0; g < bss_pkg::CAPACITY; g++) begin : g_cell
            bss_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd),
                .i_link  (w_link[g]),
                .o_link  (w_link[g+1]),
                .o_valid (w_valid[g]),
                .o_hit   (w_hit[g])
            );
        end
    endgenerate

    always_comb begin
        n_status = bss_pkg::STATUS_OK;
        n_count  = r_count;
        case (r_kind)
            bss_pkg::KIND_ADD: begin
                if (w_any_hit) begin
                    n_status = bss_pkg::STATUS_FOUND;
                end else if (w_any_free) begin
                    n_count = r_count + 1'b1;
                end else begin
                    n_status = bss_pkg::STATUS_FULL;
                end
            end
            bss_pkg::KIND_REMOVE: begin
                if (r_count == '0) begin
                    n_status = bss_pkg::STATUS_EMPTY;
                end else if (w_any_hit) begin
                    n_count = r_count - 1'b1;
                end
            end
            bss_pkg::KIND_QUERY: begin
                n_status = w_any_hit ? bss_pkg::STATUS_FOUND : bss_pkg::STATUS_NOT_FOUND;
            end
            default: begin
                n_status = bss_pkg::STATUS_OK;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_UPD;
            end
            ST_UPD: begin
                if (w_upd_fire) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_upd_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_req.kind;
            r_elem <= i_req.element;
        end
        if (w_upd_fire) begin
            r_status <= n_status;
            r_size   <= bss_pkg::to_size(n_count);
        end
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_status;
    assign o_rsp.size   = r_size;

    // The count always matches the number of occupied cells.
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("set count differs from occupied cells");

    // Values are distinct, so at most one cell can match a request.
    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit))
        else $error("more than one cell matched");

    // A completed update always presents a result in the next cycle.
    a_result_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_upd_fire |=> r_out_valid)
        else $error("update completed without a result");

    // No request is taken while the previous one is still being applied.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_UPD) && !i_req.ready)
        else $error("request accepted during an update");

endmodule

@@ tb/bounded_set_store_unit_checker.sv @@
// Checker for the bounded set store: tracks the set, predicts each result and compares it.
`timescale 1ns / 100ps

module bounded_set_store_unit_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    bss_req_if   i_req,
    bss_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [bss_pkg::STATUS_W-1:0] status;
        logic [bss_pkg::SIZE_W-1:0]   size;
    } t_reply;

    logic [bss_pkg::ELEM_W-1:0] held_value [bss_pkg::CAPACITY];
    logic                       held_valid [bss_pkg::CAPACITY];
    int                         held_count;
    t_reply                     replies_due [$];
    int                         fail_count = 0;

    // Applies one request to the tracked set and returns the result it must produce.
    task automatic apply_set_request(input logic [bss_pkg::KIND_W-1:0] kind,
                                     input logic [bss_pkg::ELEM_W-1:0] elem,
                                     output t_reply reply);
        int idx;
        int hit;
        int slot;
        hit  = -1;
        slot = -1;
        for (idx = 0; idx < bss_pkg::CAPACITY; idx++) begin
            if (hit < 0 && held_valid[idx] && held_value[idx] == elem) begin
                hit = idx;
            end
            if (slot < 0 && !held_valid[idx]) begin
                slot = idx;
            end
        end
        reply.status = bss_pkg::STATUS_OK;
        case (kind)
            bss_pkg::KIND_ADD: begin
                if (hit >= 0) begin
                    reply.status = bss_pkg::STATUS_FOUND;
                end else if (slot >= 0) begin
                    held_value[slot] = elem;
                    held_valid[slot] = 1'b1;
                    held_count++;
                end else begin
                    reply.status = bss_pkg::STATUS_FULL;
                end
            end
            bss_pkg::KIND_REMOVE: begin
                if (held_count == 0) begin
                    reply.status = bss_pkg::STATUS_EMPTY;
                end else if (hit >= 0) begin
                    held_valid[hit] = 1'b0;
                    held_count--;
                end
            end
            bss_pkg::KIND_QUERY: begin
                reply.status = (hit >= 0) ? bss_pkg::STATUS_FOUND : bss_pkg::STATUS_NOT_FOUND;
            end
            default: begin
                reply.status = bss_pkg::STATUS_OK;
            end
        endcase
        reply.size = bss_pkg::SIZE_W'(held_count);
    endtask

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t: result check: %s", $time, what);
        end
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_reply got;
        t_reply want;
        int     idx;
        if (!i_rst_n) begin
            for (idx = 0; idx < bss_pkg::CAPACITY; idx++) begin
                held_value[idx] = '0;
                held_valid[idx] = 1'b0;
            end
            held_count = 0;
            replies_due.delete();
        end else begin
            // A result accepted at this edge always belongs to an earlier request.
            if (i_rsp.valid && i_rsp.ready) begin
                got.status = i_rsp.status;
                got.size   = i_rsp.size;
                if (replies_due.size() == 0) begin
                    note_failure($sformatf("unexpected result status %0d size %0d",
                                           got.status, got.size));
                end else begin
                    want = replies_due.pop_front();
                    if (got.status !== want.status) begin
                        note_failure($sformatf("status expected %0d got %0d",
                                               want.status, got.status));
                    end
                    if (got.size !== want.size) begin
                        note_failure($sformatf("size expected %0d got %0d",
                                               want.size, got.size));
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                apply_set_request(i_req.kind, i_req.element, want);
                replies_due.push_back(want);
            end
        end
        o_pending    = replies_due.size();
        o_fail_count = fail_count;
    end

endmodule

@@ tb/bounded_set_store_unit_test.sv @@
// Testbench top for the bounded set store: clock, reset, request stimulus and the verdict.
`timescale 1ns / 100ps

module bounded_set_store_unit_test;

    localparam logic [bss_pkg::KIND_W-1:0] KIND_NOP = 2'd3;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PHASE_ITEMS   = 105;
    localparam int POOL_SIZE     = 24;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bss_req_if req_ch ();
    bss_rsp_if rsp_ch ();

    int send_idle_pct   = 0;
    int rsp_stall_pct   = 0;
    int quiet_cycles    = 0;
    int fail_count;
    int replies_pending;

    logic [bss_pkg::ELEM_W-1:0] value_pool [POOL_SIZE];

    always #6 i_clk = ~i_clk;

    bounded_set_store_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    bounded_set_store_unit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (replies_pending)
    );

    always @(posedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    // Ends the run when neither channel has moved an item for too long.
    always @(posedge i_clk) begin
        if (i_rst_n && !((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))) begin
            quiet_cycles <= quiet_cycles + 1;
        end else begin
            quiet_cycles <= 0;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("** bounded_set_store_unit: FAILED **");
            $finish;
        end
    end

    task automatic send_request(input logic [bss_pkg::KIND_W-1:0] kind,
                                input logic [bss_pkg::ELEM_W-1:0] elem);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.kind    <= kind;
        req_ch.element <= elem;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
    endtask

    // Holds the request channel until every outstanding result has come back.
    task automatic wait_for_replies();
        req_ch.valid <= 1'b0;
        do @(negedge i_clk); while (replies_pending != 0);
        @(posedge i_clk);
    endtask

    // Add-heavy stretches fill the store; remove-heavy ones drain it toward empty.
    function automatic logic [bss_pkg::KIND_W-1:0] pick_kind(input bit grow);
        int roll;
        roll = $urandom_range(99);
        if (roll < 5) begin
            return KIND_NOP;
        end
        if (grow) begin
            return (roll < 65) ? bss_pkg::KIND_ADD :
                   (roll < 85) ? bss_pkg::KIND_REMOVE : bss_pkg::KIND_QUERY;
        end
        return (roll < 25) ? bss_pkg::KIND_ADD :
               (roll < 80) ? bss_pkg::KIND_REMOVE : bss_pkg::KIND_QUERY;
    endfunction

    // Mostly values from a small pool, so that hits, a full store and an empty one occur.
    function automatic logic [bss_pkg::ELEM_W-1:0] pick_element();
        if ($urandom_range(99) < 80) begin
            return value_pool[$urandom_range(POOL_SIZE - 1)];
        end
        return $urandom;
    endfunction

    initial begin
        int idx;
        int phase;
        int n;
        req_ch.valid   <= 1'b0;
        req_ch.kind    <= bss_pkg::KIND_ADD;
        req_ch.element <= '0;
        value_pool[0] = '0;
        value_pool[1] = '1;
        for (idx = 2; idx < POOL_SIZE; idx++) begin
            value_pool[idx] = $urandom;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty-set cases, duplicates, absent values, full store, slot reuse.
        send_request(bss_pkg::KIND_QUERY, 32'h1234_5678);
        send_request(bss_pkg::KIND_REMOVE, 32'h1234_5678);
        send_request(KIND_NOP, 32'hFFFF_FFFF);
        send_request(bss_pkg::KIND_ADD, 32'h0000_0000);
        send_request(bss_pkg::KIND_ADD, 32'hFFFF_FFFF);
        send_request(bss_pkg::KIND_ADD, 32'h0000_0000);
        send_request(bss_pkg::KIND_QUERY, 32'hFFFF_FFFF);
        send_request(bss_pkg::KIND_QUERY, 32'h5555_5555);
        send_request(bss_pkg::KIND_REMOVE, 32'hAAAA_AAAA);
        send_request(bss_pkg::KIND_REMOVE, 32'h0000_0000);
        for (idx = 0; idx < bss_pkg::CAPACITY - 1; idx++) begin
            send_request(bss_pkg::KIND_ADD, 32'h1 << idx);
        end
        send_request(bss_pkg::KIND_ADD, 32'h8000_0000);
        send_request(bss_pkg::KIND_ADD, 32'hFFFF_FFFF);
        send_request(bss_pkg::KIND_REMOVE, 32'h0000_0010);
        send_request(bss_pkg::KIND_ADD, 32'h8000_0000);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    rsp_stall_pct <= 0;
                end
                1: begin
                    send_idle_pct = 45;
                    rsp_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct = 0;
                    rsp_stall_pct <= 45;
                end
                default: begin
                    send_idle_pct = 31;
                    rsp_stall_pct <= 31;
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) begin
                    wait_for_replies();
                end
                send_request(pick_kind(((n / 40) % 2) == 0), pick_element());
            end
        end

        req_ch.valid <= 1'b0;
        do @(negedge i_clk); while (replies_pending != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("** bounded_set_store_unit: PASSED **");
        end else begin
            $display("** bounded_set_store_unit: FAILED **");
        end
        $finish;
    end

endmodule
